// ----- rtl/core/assert_macros.svh -----
// Shared assertion shorthands. Both sample on clk and stand down while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define PFRS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define PFRS_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/core/pfrs_pkg.sv -----
package pfrs_pkg;

    localparam int PAGES   = 16;
    localparam int COLUMNS = 128;
    localparam int ROWS    = PAGES * 8;
    localparam int DEPTH   = PAGES * COLUMNS;

    localparam int PAGE_W = $clog2(PAGES);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(DEPTH);
    // signed width for column + step
    localparam int SXW    = ((COL_W > 8) ? COL_W : 8) + 2;
    // width for clipping compares
    localparam int CLIP_W = 10;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_SCROLL = 2'd3;

    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_Y_MIN = 2'd1;
    localparam logic [1:0] REG_X_MAX = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [3:0]        page;
        logic [6:0]        column;
        logic [7:0]        write_data;
        logic signed [7:0] x_step;
        logic signed [7:0] y_step;
    } pfrs_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } pfrs_out_t;

    typedef struct packed {
        logic       up;
        logic [7:0] amount;
    } shift_ctl_t;

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] pg,
                                                    input logic [COL_W-1:0] col);
        byte_addr = ADDR_W'(pg) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ----- rtl/core/pfrs_shift_unit.sv -----
module pfrs_shift_unit (
    input  logic [pfrs_pkg::ROWS-1:0] column_data,
    input  logic [pfrs_pkg::ROWS-1:0] region_rows,
    input  pfrs_pkg::shift_ctl_t      ctl,
    output logic [pfrs_pkg::ROWS-1:0] merged
);
    import pfrs_pkg::*;

    logic [ROWS-1:0] src;
    logic [ROWS-1:0] shifted;

    // keep only pixels inside the rectangle as source, zero fills vacated rows
    assign src     = column_data & region_rows;
    assign shifted = ctl.up ? (src >> ctl.amount) : (src << ctl.amount);
    assign merged  = (column_data & ~region_rows) | (shifted & region_rows);

endmodule

// ----- rtl/core/paged_framebuffer_region_scroll_unit.sv -----
// Paged monochrome framebuffer (PAGES pages x COLUMNS bytes, bit 0 = top pixel of
// a page) with byte write/read, clear of the configured rectangle and scroll of
// that rectangle, horizontal first and then vertical. The store is one
// single-port RAM and every command runs under a small sequencer, one command at
// a time; in_ready is high only while the sequencer is idle. Steps per command,
// from acceptance to the result beat being offered: a write runs S_WR, a read
// S_RDA and S_RDD, each then S_FIN. Clear: S_SETUP, S_PLAN, one read-merge-write
// per byte over the pages the rectangle touches times its width, then S_FIN.
// Scroll: as for clear, with the byte walk only when x_step is nonzero, plus a
// pass per column of the rectangle when y_step is nonzero (the whole column is
// read, shifted in one pass through the single shifter, and written back). An
// inverted region returns status 1 and touches nothing. A result beat still
// waiting in the output register holds the next one back until it leaves.
// Configuration writes are always accepted and must only be issued while no
// command is in flight. Bytes never written read back as undefined, so clear
// the screen after reset.
`include "assert_macros.svh"

module paged_framebuffer_region_scroll_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfrs_pkg::pfrs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfrs_pkg::pfrs_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data
);
    import pfrs_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR    = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDD   = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_PLAN  = 4'd5;
    localparam logic [3:0] S_HSRC  = 4'd6;
    localparam logic [3:0] S_HDST  = 4'd7;
    localparam logic [3:0] S_HWR   = 4'd8;
    localparam logic [3:0] S_VRD   = 4'd9;
    localparam logic [3:0] S_VCAP  = 4'd10;
    localparam logic [3:0] S_VSH   = 4'd11;
    localparam logic [3:0] S_VWR   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0] state_reg;

    // configuration registers
    logic [6:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;

    // captured command
    logic [1:0]        cmd_reg;
    logic [3:0]        page_reg;
    logic [6:0]        col_reg;
    logic [7:0]        wdata_reg;
    logic signed [7:0] xs_reg;
    logic signed [7:0] ys_reg;
    logic              addr_ok_reg;

    // clipped rectangle and walk position
    logic [COL_W-1:0]  x0_reg, x1_reg, cur_x_reg;
    logic [ROW_W-1:0]  y0_reg, y1_reg;
    logic [PAGE_W-1:0] cur_p_reg, rd_p_reg;
    logic [ROWS-1:0]   mask_reg;
    logic [ROWS-1:0]   colbuf_reg;
    logic [7:0]        src_reg;
    logic              rd_pend_reg;

    logic [7:0] rdata_reg;
    logic       status_reg;
    logic       out_valid_reg;
    pfrs_out_t  out_data_reg;

    // frame store
    logic [7:0]        mem [DEPTH];
    logic [7:0]        mem_q_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wd;

    logic               in_fire;
    logic               is_clear;
    logic               ascend;
    logic               src_in;
    logic signed [SXW-1:0] src_x;
    logic [COL_W-1:0]   src_col;
    logic [7:0]         bm;
    logic [PAGE_W-1:0]  p_first, p_last;
    logic [ROW_W-1:0]   byte_base;
    logic [ROWS-1:0]    mask_comb;
    logic [ROWS-1:0]    shift_out;
    shift_ctl_t         shift_ctl;
    logic [CLIP_W-1:0]  x1c, y1c;
    logic               inverted, empty;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_clear = (cmd_reg == CMD_CLEAR);
    // walk toward the source side so every source byte is read before it is overwritten
    assign ascend   = is_clear || !xs_reg[7];

    assign src_x   = $signed({{(SXW-COL_W){1'b0}}, cur_x_reg}) + SXW'(xs_reg);
    assign src_col = src_x[COL_W-1:0];
    assign src_in  = !is_clear
                     && (src_x >= $signed({{(SXW-COL_W){1'b0}}, x0_reg}))
                     && (src_x <= $signed({{(SXW-COL_W){1'b0}}, x1_reg}));

    assign byte_base = {cur_p_reg, 3'b000};
    assign bm        = mask_reg[byte_base +: 8];
    assign p_first   = y0_reg[ROW_W-1:3];
    assign p_last    = y1_reg[ROW_W-1:3];

    // region checks, rectangle clipped to the framebuffer
    assign inverted = (x_min_reg > x_max_reg) || (y_min_reg > y_max_reg);
    assign x1c = (CLIP_W'(x_max_reg) > CLIP_W'(COLUMNS - 1)) ? CLIP_W'(COLUMNS - 1)
                                                             : CLIP_W'(x_max_reg);
    assign y1c = (CLIP_W'(y_max_reg) > CLIP_W'(ROWS - 1)) ? CLIP_W'(ROWS - 1)
                                                          : CLIP_W'(y_max_reg);
    assign empty = (CLIP_W'(x_min_reg) > x1c) || (CLIP_W'(y_min_reg) > y1c);

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            mask_comb[i] = (ROW_W'(i) >= y0_reg) && (ROW_W'(i) <= y1_reg);
        end
    end

    assign shift_ctl.up     = !ys_reg[7];
    assign shift_ctl.amount = ys_reg[7] ? 8'(-ys_reg) : 8'(ys_reg);

    pfrs_shift_unit u_shift (
        .column_data (colbuf_reg),
        .region_rows (mask_reg),
        .ctl         (shift_ctl),
        .merged      (shift_out)
    );

    // RAM port steering
    always_comb
    begin
        mem_addr = '0;
        mem_we   = 1'b0;
        mem_wd   = '0;
        case (state_reg)
            S_WR:
            begin
                mem_addr = byte_addr(PAGE_W'(page_reg), COL_W'(col_reg));
                mem_we   = addr_ok_reg;
                mem_wd   = wdata_reg;
            end
            S_RDA:
            begin
                mem_addr = byte_addr(PAGE_W'(page_reg), COL_W'(col_reg));
            end
            S_HSRC:
            begin
                mem_addr = byte_addr(cur_p_reg, src_col);
            end
            S_HDST:
            begin
                mem_addr = byte_addr(cur_p_reg, cur_x_reg);
            end
            S_HWR:
            begin
                mem_addr = byte_addr(cur_p_reg, cur_x_reg);
                mem_we   = 1'b1;
                mem_wd   = (mem_q_reg & ~bm) | (src_reg & bm);
            end
            S_VRD:
            begin
                mem_addr = byte_addr(cur_p_reg, cur_x_reg);
            end
            S_VWR:
            begin
                mem_addr = byte_addr(cur_p_reg, cur_x_reg);
                mem_we   = 1'b1;
                mem_wd   = colbuf_reg[byte_base +: 8];
            end
            default:
            begin
                mem_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        mem_q_reg <= mem[mem_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= 7'd0;
            y_min_reg <= 7'd0;
            x_max_reg <= 7'd127;
            y_max_reg <= 7'd127;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_MIN: x_min_reg <= cfg_data;
                REG_Y_MIN: y_min_reg <= cfg_data;
                REG_X_MAX: x_max_reg <= cfg_data;
                REG_Y_MAX: y_max_reg <= cfg_data;
                default:   x_min_reg <= x_min_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_data_reg  <= '0;
            cmd_reg       <= CMD_WRITE;
            page_reg      <= '0;
            col_reg       <= '0;
            wdata_reg     <= '0;
            xs_reg        <= '0;
            ys_reg        <= '0;
            addr_ok_reg   <= 1'b0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            cur_x_reg     <= '0;
            cur_p_reg     <= '0;
            rd_p_reg      <= '0;
            mask_reg      <= '0;
            colbuf_reg    <= '0;
            src_reg       <= '0;
            rdata_reg     <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            // drop the beat once taken, unless the sequencer reloads it this cycle
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            // collect column bytes in the cycle after their address
            rd_pend_reg <= (state_reg == S_VRD);
            rd_p_reg    <= cur_p_reg;
            if (rd_pend_reg)
            begin
                colbuf_reg[{rd_p_reg, 3'b000} +: 8] <= mem_q_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg     <= in_data.command;
                        page_reg    <= in_data.page;
                        col_reg     <= in_data.column;
                        wdata_reg   <= in_data.write_data;
                        xs_reg      <= in_data.x_step;
                        ys_reg      <= in_data.y_step;
                        addr_ok_reg <= (32'(in_data.page) < PAGES)
                                       && (32'(in_data.column) < COLUMNS);
                        rdata_reg   <= '0;
                        status_reg  <= 1'b0;
                        case (in_data.command)
                            CMD_WRITE: state_reg <= S_WR;
                            CMD_READ:  state_reg <= S_RDA;
                            default:   state_reg <= S_SETUP;
                        endcase
                    end
                end
                S_WR:
                begin
                    state_reg <= S_FIN;
                end
                S_RDA:
                begin
                    state_reg <= S_RDD;
                end
                S_RDD:
                begin
                    rdata_reg <= addr_ok_reg ? mem_q_reg : 8'h00;
                    state_reg <= S_FIN;
                end
                S_SETUP:
                begin
                    if (inverted)
                    begin
                        status_reg <= 1'b1;
                        state_reg  <= S_FIN;
                    end
                    else if (empty)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        x0_reg    <= COL_W'(x_min_reg);
                        x1_reg    <= COL_W'(x1c);
                        y0_reg    <= ROW_W'(y_min_reg);
                        y1_reg    <= ROW_W'(y1c);
                        state_reg <= S_PLAN;
                    end
                end
                S_PLAN:
                begin
                    mask_reg <= mask_comb;
                    if (is_clear || (xs_reg != 8'sd0))
                    begin
                        cur_p_reg <= p_first;
                        cur_x_reg <= ascend ? x0_reg : x1_reg;
                        state_reg <= S_HSRC;
                    end
                    else if (ys_reg != 8'sd0)
                    begin
                        cur_p_reg <= '0;
                        cur_x_reg <= x0_reg;
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_HSRC:
                begin
                    state_reg <= S_HDST;
                end
                S_HDST:
                begin
                    // source outside the rectangle shifts in zeros
                    src_reg   <= src_in ? mem_q_reg : 8'h00;
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    if (cur_x_reg == (ascend ? x1_reg : x0_reg))
                    begin
                        if (cur_p_reg == p_last)
                        begin
                            if (!is_clear && (ys_reg != 8'sd0))
                            begin
                                cur_p_reg <= '0;
                                cur_x_reg <= x0_reg;
                                state_reg <= S_VRD;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            cur_p_reg <= cur_p_reg + 1'b1;
                            cur_x_reg <= ascend ? x0_reg : x1_reg;
                            state_reg <= S_HSRC;
                        end
                    end
                    else
                    begin
                        cur_x_reg <= ascend ? (cur_x_reg + 1'b1) : (cur_x_reg - 1'b1);
                        state_reg <= S_HSRC;
                    end
                end
                S_VRD:
                begin
                    if (cur_p_reg == PAGE_W'(PAGES - 1))
                    begin
                        state_reg <= S_VCAP;
                    end
                    else
                    begin
                        cur_p_reg <= cur_p_reg + 1'b1;
                    end
                end
                S_VCAP:
                begin
                    // last byte of the column lands this cycle
                    cur_p_reg <= '0;
                    state_reg <= S_VSH;
                end
                S_VSH:
                begin
                    colbuf_reg <= shift_out;
                    state_reg  <= S_VWR;
                end
                S_VWR:
                begin
                    if (cur_p_reg == PAGE_W'(PAGES - 1))
                    begin
                        cur_p_reg <= '0;
                        if (cur_x_reg == x1_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            cur_x_reg <= cur_x_reg + 1'b1;
                            state_reg <= S_VRD;
                        end
                    end
                    else
                    begin
                        cur_p_reg <= cur_p_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.read_data <= rdata_reg;
                        out_data_reg.status    <= status_reg;
                        out_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PFRS_ASSERT_ALWAYS(a_we_states, !mem_we || (state_reg == S_WR) || (state_reg == S_HWR) || (state_reg == S_VWR), "frame store written outside a write step")
    `PFRS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "accepted a second beat while busy")
    `PFRS_ASSERT_ALWAYS(a_status_region, !((state_reg == S_FIN) && status_reg) || cmd_reg[1], "error status on a byte access")
    `PFRS_ASSERT_ALWAYS(a_hwalk_inside, (state_reg != S_HWR) || ((cur_x_reg >= x0_reg) && (cur_x_reg <= x1_reg)), "horizontal walk left the rectangle")

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfrs_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    pfrs_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    pfrs_out_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [6:0] cfg_data = '0;

    // Shadow of the framebuffer and the region registers
    logic [7:0] shadow_fb [0:DEPTH-1];
    int         win_x0 = 0;
    int         win_y0 = 0;
    int         win_x1 = 127;
    int         win_y1 = 127;

    pfrs_out_t  pending_beats [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         hold_request = 1'b0;
    int         burst_left = 0;

    always #5 clk = ~clk;

    paged_framebuffer_region_scroll_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pixel(int x, int y);
        return shadow_fb[(y >> 3) * COLUMNS + x][y & 7];
    endfunction

    function automatic void put_pixel(int x, int y, int v);
        shadow_fb[(y >> 3) * COLUMNS + x][y & 7] = v[0];
    endfunction

    // Apply one command to the shadow framebuffer and return its result beat.
    function automatic pfrs_out_t framebuffer_predict(pfrs_in_t cmd);
        pfrs_out_t res;
        int x1;
        int y1;
        int xs;
        int ys;
        int s;
        res = '0;
        xs = int'(cmd.x_step);
        ys = int'(cmd.y_step);
        x1 = (win_x1 > COLUMNS - 1) ? COLUMNS - 1 : win_x1;
        y1 = (win_y1 > ROWS - 1) ? ROWS - 1 : win_y1;
        if (cmd.command == CMD_WRITE)
        begin
            shadow_fb[cmd.page * COLUMNS + cmd.column] = cmd.write_data;
        end
        else if (cmd.command == CMD_READ)
        begin
            res.read_data = shadow_fb[cmd.page * COLUMNS + cmd.column];
        end
        else if (win_x0 > win_x1 || win_y0 > win_y1)
        begin
            res.status = 1'b1;
        end
        else if (win_x0 <= x1 && win_y0 <= y1)
        begin
            if (cmd.command == CMD_CLEAR)
            begin
                for (int y = win_y0; y <= y1; y++)
                    for (int x = win_x0; x <= x1; x++)
                        put_pixel(x, y, 0);
            end
            else
            begin
                // Horizontal pass first, in place, walking toward the vacated edge.
                if (xs > 0)
                begin
                    for (int y = win_y0; y <= y1; y++)
                        for (int x = win_x0; x <= x1; x++)
                        begin
                            s = x + xs;
                            put_pixel(x, y, (s <= x1) ? pixel(s, y) : 0);
                        end
                end
                else if (xs < 0)
                begin
                    for (int y = win_y0; y <= y1; y++)
                        for (int x = x1; x >= win_x0; x--)
                        begin
                            s = x + xs;
                            put_pixel(x, y, (s >= win_x0) ? pixel(s, y) : 0);
                        end
                end
                if (ys > 0)
                begin
                    for (int x = win_x0; x <= x1; x++)
                        for (int y = win_y0; y <= y1; y++)
                        begin
                            s = y + ys;
                            put_pixel(x, y, (s <= y1) ? pixel(x, s) : 0);
                        end
                end
                else if (ys < 0)
                begin
                    for (int x = win_x0; x <= x1; x++)
                        for (int y = y1; y >= win_y0; y--)
                        begin
                            s = y + ys;
                            put_pixel(x, y, (s >= win_y0) ? pixel(x, s) : 0);
                        end
                end
            end
        end
        return res;
    endfunction

    // Result side: check each accepted beat, stall on a pattern of its own,
    // and honor a long hold-off when a test asks for one.
    always @(posedge clk or negedge rst_n)
    begin
        int hold_count;
        pfrs_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_beats.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat %h", out_data);
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (out_data.read_data !== want.read_data ||
                        out_data.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: read_data exp %h got %h, status exp %b got %b",
                                     want.read_data, out_data.read_data,
                                     want.status, out_data.status);
                    end
                end
            end
            if (hold_request && hold_count == 0)
                hold_count = 400;
            if (hold_count > 0)
            begin
                hold_count--;
                out_ready <= 1'b0;
            end
            else if (cycle_count[9])
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Offer one command beat and hold it until accepted; gaps come between bursts.
    task automatic send_cmd(input pfrs_in_t cmd);
        in_data  <= cmd;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_beats.push_back(framebuffer_predict(cmd));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 1))
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // Lower valid and wait until every expected beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_index <= idx;
        cfg_data  <= val[6:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_X_MIN: win_x0 = val & 127;
            REG_Y_MIN: win_y0 = val & 127;
            REG_X_MAX: win_x1 = val & 127;
            default:   win_y1 = val & 127;
        endcase
        @(posedge clk);
    endtask

    task automatic set_region(input int x0, input int y0, input int x1, input int y1);
        drain();
        write_reg(REG_X_MIN, x0);
        write_reg(REG_Y_MIN, y0);
        write_reg(REG_X_MAX, x1);
        write_reg(REG_Y_MAX, y1);
    endtask

    function automatic pfrs_in_t make_cmd(logic [1:0] op, int pg, int col, int wd,
                                          int xs, int ys);
        pfrs_in_t c;
        c.command    = op;
        c.page       = pg[3:0];
        c.column     = col[6:0];
        c.write_data = wd[7:0];
        c.x_step     = xs[7:0];
        c.y_step     = ys[7:0];
        return c;
    endfunction

    // Clear the whole screen so every byte is defined, then hit address extremes.
    task automatic test_byte_access();
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_WRITE, 0, 0, 8'hFF, 0, 0));
        send_cmd(make_cmd(CMD_WRITE, 15, 127, 8'h80, -1, -1));
        send_cmd(make_cmd(CMD_WRITE, 7, 64, 8'h5A, 0, 0));
        send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_READ, 15, 127, 8'hFF, 127, -128));
        send_cmd(make_cmd(CMD_READ, 7, 64, 0, 0, 0));
        send_cmd(make_cmd(CMD_READ, 3, 5, 0, 0, 0));
    endtask

    // Small region: scroll with zero, small and extreme steps, then clear.
    task automatic test_scroll_extremes();
        set_region(0, 0, 9, 17);
        for (int i = 0; i < 6; i++)
            send_cmd(make_cmd(CMD_WRITE, i % 3, i, $urandom_range(0, 255), 0, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 1, -1));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, -1, 3));
        send_cmd(make_cmd(CMD_READ, 0, 1, 0, 0, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 127, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, -128, -128));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 0, 127));
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_READ, 1, 2, 0, 0, 0));
        // One-pixel region at the far corner.
        set_region(127, 127, 127, 127);
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 1, 1));
        send_cmd(make_cmd(CMD_READ, 15, 127, 0, 0, 0));
    endtask

    // Inverted region on either axis: clear and scroll report status and change nothing.
    task automatic test_inverted_region();
        set_region(50, 0, 49, 127);
        send_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 5, 5));
        set_region(0, 90, 127, 20);
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, -3, 2));
        send_cmd(make_cmd(CMD_READ, 7, 64, 0, 0, 0));
    endtask

    // Full-screen scroll in both axes once.
    task automatic test_full_screen();
        set_region(0, 0, 127, 127);
        send_cmd(make_cmd(CMD_WRITE, 9, 100, 8'hC3, 0, 0));
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 3, -5));
        send_cmd(make_cmd(CMD_READ, 9, 97, 0, 0, 0));
    endtask

    // Hold the result side off while commands keep coming; the block must stall.
    task automatic test_backpressure();
        set_region(4, 4, 11, 19);
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            send_cmd(make_cmd(i[0] ? CMD_READ : CMD_WRITE, i, i + 4,
                              $urandom_range(0, 255), 0, 0));
            hold_request = 1'b0;
        end
        send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 2, 2));
        drain();
    endtask

    function automatic int rand_step();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(0, 1) ? 127 : -128;
            2:       return int'($signed(8'($urandom_range(0, 255))));
            default: return $urandom_range(0, 12) - 6;
        endcase
    endfunction

    // Random phases: fresh region each phase, then a mix of all four commands.
    task automatic test_random_traffic();
        int x0;
        int y0;
        for (int ph = 0; ph < 5; ph++)
        begin
            x0 = $urandom_range(0, 127);
            y0 = $urandom_range(0, 127);
            if ($urandom_range(0, 6) == 0)
                set_region(x0, y0, $urandom_range(0, 127), $urandom_range(0, 127));
            else
                set_region(x0, y0, (x0 + $urandom_range(0, 15) > 127) ? 127 :
                           x0 + $urandom_range(0, 15),
                           (y0 + $urandom_range(0, 23) > 127) ? 127 :
                           y0 + $urandom_range(0, 23));
            for (int i = 0; i < 20; i++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:
                        send_cmd(make_cmd(CMD_WRITE, $urandom_range(0, 15),
                                 $urandom_range(0, 127), $urandom_range(0, 255),
                                 rand_step(), rand_step()));
                    7, 8, 9, 10, 11, 12:
                        send_cmd(make_cmd(CMD_READ, $urandom_range(0, 15),
                                 $urandom_range(0, 127), $urandom_range(0, 255),
                                 rand_step(), rand_step()));
                    13, 14:
                        send_cmd(make_cmd(CMD_CLEAR, $urandom_range(0, 15),
                                 $urandom_range(0, 127), $urandom_range(0, 255),
                                 rand_step(), rand_step()));
                    default:
                        send_cmd(make_cmd(CMD_SCROLL, $urandom_range(0, 15),
                                 $urandom_range(0, 127), $urandom_range(0, 255),
                                 rand_step(), rand_step()));
                endcase
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            shadow_fb[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_byte_access();
        test_scroll_extremes();
        test_inverted_region();
        test_full_screen();
        test_backpressure();
        test_random_traffic();
        drain();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pfrs_pkg.sv
rtl/core/pfrs_shift_unit.sv
rtl/core/paged_framebuffer_region_scroll_unit.sv
sim/tb.sv
